### rtl/address_region_decoder_macros.svh
// assertion helpers for address_region_decoder.sv
`ifndef ADDRESS_REGION_DECODER_MACROS_SVH
`define ADDRESS_REGION_DECODER_MACROS_SVH

// plain property on aclk, off while reset is held
`define ARD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication on aclk
`define ARD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on aclk
`define ARD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ard_pkg.sv
package ard_pkg;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 32;
    localparam int TAG_OUT_W = 16;
    localparam int IDX_OUT_W = 7;
    localparam int BYTE_W    = 8;

    localparam logic [BYTE_W-1:0] NOERROR_MASK_RESET = 8'd128;

    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_ADD    = 1'b1;

    // token walking down the chain of region cells
    typedef struct packed {
        logic valid;
        logic mode;
        logic found;
        logic overlap;
    } ard_tok_t;

    // table write broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] lim;
        logic              nz;
    } ard_wr_t;

endpackage

### rtl/address_region_decoder.sv
// a request walks as one token through the chain of region cells, then its result is loaded into m_*
// one request at a time: s_ready is high only while idle, so the next request is taken only once
//   the last result is in the m_* register, which waits for m_ready to be free
// reset: synchronous, active low on aresetn; every slot is marked free at once,
//   noerror_mask returns to 128, no result is pending
`include "address_region_decoder_macros.svh"

module address_region_decoder import ard_pkg::*; #(
    parameter int NUM_REGIONS = 128,
    parameter int TAG_WIDTH   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [ADDR_W-1:0]    s_address,
    input  logic [SIZE_W-1:0]    s_region_size,
    input  logic [TAG_OUT_W-1:0] s_region_tag,
    input  logic [BYTE_W-1:0]    s_access_size,
    input  logic [BYTE_W-1:0]    s_access_type,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_add_ok,
    output logic                 m_hit,
    output logic [IDX_OUT_W-1:0] m_hit_index,
    output logic [TAG_OUT_W-1:0] m_handler_tag,
    output logic [ADDR_W-1:0]    m_address_out,
    output logic [BYTE_W-1:0]    m_size_out,
    output logic                 m_write_flag,
    // configuration write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [BYTE_W-1:0]    cfg_noerror_mask
);

    localparam int IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;

    // configuration register
    logic [BYTE_W-1:0] noerror_mask_reg;

    // captured request, held steady while the token walks the chain
    logic                 mode_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    lim_reg;
    logic                 nz_reg;
    logic [TAG_WIDTH-1:0] rtag_reg;
    logic [BYTE_W-1:0]    asize_reg;
    logic                 wflag_reg;

    // token leaving the last cell
    ard_tok_t             res_tok_reg;
    logic [IDX_W-1:0]     res_idx_reg;
    logic [TAG_WIDTH-1:0] res_tag_reg;

    // result register
    logic                 m_valid_reg;
    logic                 add_ok_reg;
    logic                 hit_reg;
    logic [IDX_OUT_W-1:0] hit_index_reg;
    logic [TAG_OUT_W-1:0] handler_tag_reg;
    logic [ADDR_W-1:0]    address_out_reg;
    logic [BYTE_W-1:0]    size_out_reg;
    logic                 write_flag_reg;

    logic accept;
    logic out_free;
    logic load_out;
    logic res_add_ok;
    logic res_hit;

    // width adapters for the tag and slot index
    logic [TAG_WIDTH+TAG_OUT_W-1:0] tag_in_wide;
    logic [TAG_WIDTH+TAG_OUT_W-1:0] tag_out_wide;
    logic [IDX_W+IDX_OUT_W-1:0]     idx_out_wide;

    // chain wiring: entry k feeds cell k, entry k+1 is its registered output
    ard_tok_t             tok_chain [0:NUM_REGIONS];
    logic [IDX_W-1:0]     idx_chain [0:NUM_REGIONS];
    logic [TAG_WIDTH-1:0] tag_chain [0:NUM_REGIONS];
    logic [NUM_REGIONS-1:0] tok_valid_vec;

    ard_wr_t              wr;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign tag_in_wide  = {{TAG_WIDTH{1'b0}}, s_region_tag};
    assign tag_out_wide = {{TAG_OUT_W{1'b0}}, res_tag_reg};
    assign idx_out_wide = {{IDX_OUT_W{1'b0}}, res_idx_reg};

    // result is stored once the output register can take it
    assign out_free   = !m_valid_reg || m_ready;
    assign load_out   = (state_reg == ST_DONE) && out_free;
    assign res_add_ok = (mode_reg == MODE_ADD) && res_tok_reg.found && !res_tok_reg.overlap;
    assign res_hit    = (mode_reg == MODE_DECODE) && res_tok_reg.found;

    // table write happens in the same cycle that the add result is loaded
    assign wr.en   = load_out && res_add_ok;
    assign wr.base = addr_reg;
    assign wr.lim  = lim_reg;
    assign wr.nz   = nz_reg;

    // token enters cell 0 for one cycle in the start state
    assign tok_chain[0].valid   = (state_reg == ST_START);
    assign tok_chain[0].mode    = mode_reg;
    assign tok_chain[0].found   = 1'b0;
    assign tok_chain[0].overlap = 1'b0;
    assign idx_chain[0]         = '0;
    assign tag_chain[0]         = '0;

    for (genvar k = 0; k < NUM_REGIONS; k++) begin : g_cell
        ard_cell #(
            .TAG_WIDTH  (TAG_WIDTH),
            .IDX_W      (IDX_W),
            .CELL_INDEX (k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .req_addr (addr_reg),
            .req_lim  (lim_reg),
            .wr       (wr),
            .wr_idx   (res_idx_reg),
            .wr_tag   (rtag_reg),
            .tok_in   (tok_chain[k]),
            .idx_in   (idx_chain[k]),
            .tag_in   (tag_chain[k]),
            .tok_out  (tok_chain[k+1]),
            .idx_out  (idx_chain[k+1]),
            .tag_out  (tag_chain[k+1])
        );
        assign tok_valid_vec[k] = tok_chain[k+1].valid;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (tok_chain[NUM_REGIONS].valid) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            noerror_mask_reg <= NOERROR_MASK_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                noerror_mask_reg <= cfg_noerror_mask;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, chain result capture and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_mode;
            addr_reg  <= s_address;
            // region end wraps modulo 2^32
            lim_reg   <= s_address + s_region_size;
            nz_reg    <= (s_region_size != '0);
            rtag_reg  <= tag_in_wide[TAG_WIDTH-1:0];
            asize_reg <= s_access_size;
            // any access type bit outside the mask marks a write
            wflag_reg <= |(s_access_type & ~noerror_mask_reg);
        end
        if ((state_reg == ST_RUN) && tok_chain[NUM_REGIONS].valid) begin
            res_tok_reg <= tok_chain[NUM_REGIONS];
            res_idx_reg <= idx_chain[NUM_REGIONS];
            res_tag_reg <= tag_chain[NUM_REGIONS];
        end
        if (load_out) begin
            add_ok_reg      <= res_add_ok;
            hit_reg         <= res_hit;
            hit_index_reg   <= (res_add_ok || res_hit) ? idx_out_wide[IDX_OUT_W-1:0] : '0;
            handler_tag_reg <= res_hit ? tag_out_wide[TAG_OUT_W-1:0] : '0;
            address_out_reg <= addr_reg;
            size_out_reg    <= (mode_reg == MODE_DECODE) ? asize_reg : '0;
            write_flag_reg  <= (mode_reg == MODE_DECODE) && wflag_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_add_ok      = add_ok_reg;
    assign m_hit         = hit_reg;
    assign m_hit_index   = hit_index_reg;
    assign m_handler_tag = handler_tag_reg;
    assign m_address_out = address_out_reg;
    assign m_size_out    = size_out_reg;
    assign m_write_flag  = write_flag_reg;

    // checks
    // only one request token is ever in the chain
    `ARD_ASSERT(a_one_token, $countones(tok_valid_vec) <= 1, "more than one token in chain")
    // the token leaves the chain only while the sequencer waits for it
    `ARD_ASSERT_IMPL(a_exit_in_run, tok_chain[NUM_REGIONS].valid, state_reg == ST_RUN, "token exit outside run")
    // an accepted request starts a chain walk on the next cycle
    `ARD_ASSERT_NEXT(a_accept_start, accept, state_reg == ST_START && tok_chain[0].valid, "accept did not start walk")
    // a table write never coincides with a decode result
    `ARD_ASSERT_IMPL(a_write_is_add, wr.en, mode_reg == MODE_ADD && load_out, "table write outside add")

endmodule

### rtl/ard_cell.sv
module ard_cell import ard_pkg::*; #(
    parameter int TAG_WIDTH  = 16,
    parameter int IDX_W      = 7,
    parameter int CELL_INDEX = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [ADDR_W-1:0]    req_addr,
    input  logic [ADDR_W-1:0]    req_lim,
    input  ard_wr_t              wr,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic [TAG_WIDTH-1:0] wr_tag,
    input  ard_tok_t             tok_in,
    input  logic [IDX_W-1:0]     idx_in,
    input  logic [TAG_WIDTH-1:0] tag_in,
    output ard_tok_t             tok_out,
    output logic [IDX_W-1:0]     idx_out,
    output logic [TAG_WIDTH-1:0] tag_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic [ADDR_W-1:0]    base_reg;
    logic [ADDR_W-1:0]    lim_reg;
    logic [TAG_WIDTH-1:0] rtag_reg;
    logic                 nz_reg;

    ard_tok_t             tok_reg, tok_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [TAG_WIDTH-1:0] tag_reg, tag_next;

    logic sel;
    logic in_rng;
    logic covers;

    assign sel    = wr.en && (wr_idx == MY_IDX);
    // free slots never match
    assign in_rng = nz_reg && (base_reg <= req_addr) && (lim_reg > req_addr);
    assign covers = nz_reg && (req_addr <= base_reg) && (req_lim > base_reg);

    always_comb begin
        tok_next = tok_in;
        idx_next = idx_in;
        tag_next = tag_in;
        if (tok_in.valid) begin
            if (tok_in.mode == MODE_ADD) begin
                tok_next.overlap = tok_in.overlap | in_rng | covers;
                if (!tok_in.found && !nz_reg) begin
                    tok_next.found = 1'b1;
                    idx_next       = MY_IDX;
                end
            end else begin
                if (!tok_in.found && in_rng) begin
                    tok_next.found = 1'b1;
                    idx_next       = MY_IDX;
                    tag_next       = rtag_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nz_reg  <= 1'b0;
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
            if (sel) begin
                nz_reg <= wr.nz;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        tag_reg <= tag_next;
        if (sel) begin
            base_reg <= wr.base;
            lim_reg  <= wr.lim;
            rtag_reg <= wr_tag;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;
    assign tag_out = tag_reg;

endmodule
